// ===== src/log_contrast_pixel_stream_unit_assert.svh =====
// assertion macros used by the top rtl file
`ifndef LOG_CONTRAST_PIXEL_STREAM_UNIT_ASSERT_SVH
`define LOG_CONTRAST_PIXEL_STREAM_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcps check failed");

// next-cycle implication, checked out of reset
`define LCPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcps check failed");

`endif

// ===== src/lcps_pkg.sv =====
package lcps_pkg;

    // field widths
    localparam int PIX_W          = 8;
    localparam int PIXEL_BITS_DEF = 8;

    // log2 in Q4.12, working precision of the squaring loop
    localparam int LOG_W         = 16;
    localparam int LOG_FRAC_WORK = 24;
    localparam int LOG_FRAC_OUT  = 12;

    // numerator 255 * log fits in log width plus one byte
    localparam int NUM_W = LOG_W + PIX_W;
    localparam int CNT_W = $clog2(PIX_W);

    localparam logic [PIX_W-1:0] OUT_MAX = 8'd255;
    localparam logic [PIX_W-1:0] OUT_MIN = 8'd0;

    localparam int TABLE_DEPTH = 1 << PIX_W;

    typedef logic [LOG_W-1:0] log_table_t [TABLE_DEPTH];

    // divider status toward the output stage
    typedef struct packed {
        logic             busy;
        logic             done;
        logic             last;
        logic [PIX_W-1:0] quot;
    } div_status_t;

    // log2(n) in Q4.12, rounded half up; mantissa squared with Q1.31 truncation
    function automatic logic [LOG_W-1:0] log2_q12(input int unsigned n);
        int unsigned      ip;
        int unsigned      frac;
        longint unsigned  m;
        longint unsigned  full;
        ip   = 0;
        frac = 0;
        for (int k = 1; k < 32; k++)
        begin
            if ((n >> k) != 0)
                ip = k;
        end
        m = longint'(n) << (31 - ip);
        for (int i = 0; i < LOG_FRAC_WORK; i++)
        begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m    = m >> 1;
                frac = frac | 32'd1;
            end
        end
        full = (longint'(ip) << LOG_FRAC_WORK) | longint'(frac);
        full = full + (64'd1 << (LOG_FRAC_WORK - LOG_FRAC_OUT - 1));
        return LOG_W'(full >> (LOG_FRAC_WORK - LOG_FRAC_OUT));
    endfunction

    // entry k holds log2(k + 1)
    function automatic log_table_t build_log_table();
        log_table_t t;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            t[k] = log2_q12(k + 1);
        end
        return t;
    endfunction

    localparam log_table_t LOG_TABLE = build_log_table();

endpackage

// ===== src/lcps_divider.sv =====
module lcps_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lcps_pkg::LOG_W-1:0]   lp,
    input  logic [lcps_pkg::LOG_W-1:0]   lm,
    input  logic                         last,
    input  logic                         take,
    output lcps_pkg::div_status_t        status
);

    typedef enum logic [1:0] {IDLE, CHECK, ITER, DONE} state_t;

    state_t                            state_reg;
    logic [lcps_pkg::NUM_W-1:0]        rem_reg;
    logic [lcps_pkg::NUM_W-1:0]        dsh_reg;
    logic [lcps_pkg::PIX_W-1:0]        quot_reg;
    logic [lcps_pkg::CNT_W-1:0]        cnt_reg;
    logic                              last_reg;
    logic                              fits;

    // trial compare of the partial remainder against the shifted divisor
    assign fits = (rem_reg >= dsh_reg);

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            quot_reg  <= '0;
            last_reg  <= 1'b0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        // 255 * lp as lp * 256 - lp
                        rem_reg   <= lcps_pkg::NUM_W'({lp, 8'h00}) - lcps_pkg::NUM_W'(lp);
                        dsh_reg   <= lcps_pkg::NUM_W'({lm, 8'h00});
                        last_reg  <= last;
                        state_reg <= CHECK;
                    end
                end
                CHECK:
                begin
                    // zero scale gives zero, a quotient of 256 or more saturates
                    if (dsh_reg == '0)
                    begin
                        quot_reg  <= lcps_pkg::OUT_MIN;
                        state_reg <= DONE;
                    end
                    else if (fits)
                    begin
                        quot_reg  <= lcps_pkg::OUT_MAX;
                        state_reg <= DONE;
                    end
                    else
                    begin
                        dsh_reg   <= dsh_reg >> 1;
                        cnt_reg   <= lcps_pkg::CNT_W'(lcps_pkg::PIX_W - 1);
                        state_reg <= ITER;
                    end
                end
                ITER:
                begin
                    if (fits)
                        rem_reg <= rem_reg - dsh_reg;
                    quot_reg <= {quot_reg[lcps_pkg::PIX_W-2:0], fits};
                    dsh_reg  <= dsh_reg >> 1;
                    if (cnt_reg == '0)
                        state_reg <= DONE;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                DONE:
                begin
                    if (take)
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != IDLE);
    assign status.done = (state_reg == DONE);
    assign status.last = last_reg;
    assign status.quot = quot_reg;

endmodule

// ===== src/lcps_range_track.sv =====
module lcps_range_track (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcps_pkg::div_status_t             status,
    output logic                              take,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [3*lcps_pkg::PIX_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast
);

    logic                          valid_reg;
    logic [lcps_pkg::PIX_W-1:0]    run_max_reg;
    logic [lcps_pkg::PIX_W-1:0]    run_min_reg;
    logic [lcps_pkg::PIX_W-1:0]    max_next;
    logic [lcps_pkg::PIX_W-1:0]    min_next;
    logic [lcps_pkg::PIX_W-1:0]    pix_reg;
    logic [lcps_pkg::PIX_W-1:0]    min_reg;
    logic [lcps_pkg::PIX_W-1:0]    max_reg;
    logic                          last_reg;

    // result moves in when the output register is empty or being drained
    assign take = status.done && (!valid_reg || m_axis_tready);

    // trackers including the present result
    always_comb
    begin
        max_next = (status.quot > run_max_reg) ? status.quot : run_max_reg;
        min_next = (status.quot < run_min_reg) ? status.quot : run_min_reg;
    end

    // output register and frame trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            run_max_reg <= lcps_pkg::OUT_MIN;
            run_min_reg <= lcps_pkg::OUT_MAX;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
            if (status.last)
            begin
                run_max_reg <= lcps_pkg::OUT_MIN;
                run_min_reg <= lcps_pkg::OUT_MAX;
            end
            else
            begin
                run_max_reg <= max_next;
                run_min_reg <= min_next;
            end
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg  <= status.quot;
            min_reg  <= min_next;
            max_reg  <= max_next;
            last_reg <= status.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {max_reg, min_reg, pix_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== src/log_contrast_pixel_stream_unit.sv =====
// an input transfer registers the log lookups, then the 8-step serial divider runs;
//   zero scale or saturation skips its steps; the output stage registers the result
// one pixel in flight: the next waits until the divider has handed on its result
// reset: asynchronous active low; clears control state, trackers to min 255 / max 0,
//   max_input_pixel to 255
`include "log_contrast_pixel_stream_unit_assert.svh"

module log_contrast_pixel_stream_unit #(
    parameter int PIXEL_BITS = lcps_pkg::PIXEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcps_pkg::PIX_W-1:0]        cfg_data,     // max_input_pixel
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lcps_pkg::PIX_W-1:0]        s_axis_tdata, // pixel_in
    input  logic                              s_axis_tlast,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [3*lcps_pkg::PIX_W-1:0]      m_axis_tdata, // pixel_out, min_out, max_out
    output logic                              m_axis_tlast
);

    localparam logic [lcps_pkg::PIX_W-1:0] PIXEL_MASK =
        lcps_pkg::PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

    logic [lcps_pkg::PIX_W-1:0]   max_in_reg;
    logic                         go_reg;
    logic [lcps_pkg::LOG_W-1:0]   lp_reg;
    logic [lcps_pkg::LOG_W-1:0]   lm_reg;
    logic                         last_reg;
    logic [lcps_pkg::PIX_W-1:0]   pix_masked;
    logic [lcps_pkg::PIX_W-1:0]   max_masked;
    logic                         in_xfer;
    logic                         div_take;
    lcps_pkg::div_status_t        div_stat;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_in_reg <= lcps_pkg::OUT_MAX;
        else if (cfg_valid && cfg_ready)
            max_in_reg <= cfg_data;
    end

    // one pixel in flight
    assign s_axis_tready = !div_stat.busy && !go_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign pix_masked = s_axis_tdata & PIXEL_MASK;
    assign max_masked = max_in_reg & PIXEL_MASK;

    // log lookup of pixel + 1 and maximum + 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            go_reg <= 1'b0;
        else
            go_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            lp_reg   <= lcps_pkg::LOG_TABLE[pix_masked];
            lm_reg   <= lcps_pkg::LOG_TABLE[max_masked];
            last_reg <= s_axis_tlast;
        end
    end

    lcps_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (go_reg),
        .lp     (lp_reg),
        .lm     (lm_reg),
        .last   (last_reg),
        .take   (div_take),
        .status (div_stat)
    );

    lcps_range_track u_range_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .status        (div_stat),
        .take          (div_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // checks
    `LCPS_ASSERT_NOW(a_no_accept_busy, in_xfer, !div_stat.busy && !go_reg)
    `LCPS_ASSERT_NEXT(a_take_shows_result, div_take, m_axis_tvalid)
    `LCPS_ASSERT_NOW(a_range_order, m_axis_tvalid, (m_axis_tdata[15:8] <= m_axis_tdata[7:0]) && (m_axis_tdata[7:0] <= m_axis_tdata[23:16]))

endmodule

// ===== dv/tb_log_contrast_pixel_stream_unit.sv =====
module tb_log_contrast_pixel_stream_unit;

    localparam int PW          = lcps_pkg::PIX_W;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 50;
    localparam int SCRIPT_ROWS = 22;

    // one result as it leaves the block
    typedef struct packed {
        logic [PW-1:0] level;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        logic          last;
    } pixel_result_t;

    // one directed row: scale to run under, pixel, and an optional fixed level
    typedef struct packed {
        logic [PW-1:0] scale;
        logic [PW-1:0] pix;
        logic          last;
        logic          fixed;
        logic [PW-1:0] level;
    } script_row_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [PW-1:0]   cfg_data;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [PW-1:0]   s_axis_tdata;   // pixel_in
    logic            s_axis_tlast;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [3*PW-1:0] m_axis_tdata;   // pixel_out, min_out, max_out
    logic            m_axis_tlast;

    // sideband that travels with the driven pixel
    logic            pin_fixed;
    logic [PW-1:0]   pin_level;

    // shadow of the block's register and trackers
    logic [PW-1:0]   scale_now;
    logic [PW-1:0]   track_lo;
    logic [PW-1:0]   track_hi;

    pixel_result_t   pending_results[$];
    int              pixels_sent;
    int              results_seen;
    int              mismatches;
    bit              src_idle;
    bit              sink_idle;
    bit              hold_req;

    script_row_t script [SCRIPT_ROWS] = '{
        // reset scale: zero and full range read off directly
        '{8'd255, 8'd0,   1'b0, 1'b1, 8'd0},
        '{8'd255, 8'd255, 1'b0, 1'b1, 8'd255},
        '{8'd255, 8'd128, 1'b0, 1'b0, 8'd0},
        '{8'd255, 8'd1,   1'b1, 1'b0, 8'd0},
        '{8'd255, 8'd255, 1'b1, 1'b1, 8'd255},
        // zero maximum gives zero everywhere
        '{8'd0,   8'd0,   1'b0, 1'b1, 8'd0},
        '{8'd0,   8'd255, 1'b0, 1'b1, 8'd0},
        '{8'd0,   8'd77,  1'b1, 1'b1, 8'd0},
        // maximum of one: pixels above it saturate
        '{8'd1,   8'd0,   1'b0, 1'b1, 8'd0},
        '{8'd1,   8'd1,   1'b0, 1'b1, 8'd255},
        '{8'd1,   8'd255, 1'b0, 1'b1, 8'd255},
        '{8'd1,   8'd3,   1'b1, 1'b1, 8'd255},
        // mid scale
        '{8'd128, 8'd128, 1'b0, 1'b1, 8'd255},
        '{8'd128, 8'd200, 1'b0, 1'b1, 8'd255},
        '{8'd128, 8'd64,  1'b0, 1'b0, 8'd0},
        '{8'd128, 8'd0,   1'b1, 1'b1, 8'd0},
        // scale one below full, pixel above it saturates
        '{8'd254, 8'd254, 1'b0, 1'b1, 8'd255},
        '{8'd254, 8'd255, 1'b0, 1'b1, 8'd255},
        '{8'd254, 8'd170, 1'b0, 1'b0, 8'd0},
        '{8'd254, 8'd85,  1'b1, 1'b0, 8'd0},
        // back to full scale, alternating bit patterns
        '{8'd255, 8'd85,  1'b0, 1'b0, 8'd0},
        '{8'd255, 8'd170, 1'b1, 1'b0, 8'd0}
    };

    log_contrast_pixel_stream_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // log2 of n as q4.12: normalize, square out 24 fraction bits, round half up
    function automatic logic [15:0] log2_q412(input logic [8:0] n);
        int          top;
        logic [63:0] mant;
        logic [23:0] frac;
        logic [31:0] full;
        if (n == 9'd0)
            return 16'd0;
        top = 0;
        for (int b = 0; b < 9; b++)
        begin
            if (n[b])
                top = b;
        end
        mant = 64'(n) << (31 - top);
        frac = '0;
        for (int i = 0; i < 24; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = {frac[22:0], mant[32]};
            if (mant[32])
                mant = mant >> 1;
        end
        full = (32'(top) << 24) | 32'(frac);
        full = full + 32'd2048;
        return full[27:12];
    endfunction

    // transformed level plus frame trackers for one pixel
    function automatic pixel_result_t predict_pixel(input logic [PW-1:0] pix,
                                                    input logic lst);
        pixel_result_t r;
        logic [15:0]   lp;
        logic [15:0]   lm;
        logic [31:0]   q;
        lp = log2_q412(9'(pix) + 9'd1);
        lm = log2_q412(9'(scale_now) + 9'd1);
        q  = '0;
        if (lm != 16'd0)
        begin
            q = (32'd255 * 32'(lp)) / 32'(lm);
            if (q > 32'd255)
                q = 32'd255;
        end
        if (q[PW-1:0] > track_hi)
            track_hi = q[PW-1:0];
        if (q[PW-1:0] < track_lo)
            track_lo = q[PW-1:0];
        r.level = q[PW-1:0];
        r.lo    = track_lo;
        r.hi    = track_hi;
        r.last  = lst;
        // trackers restart after the last pixel of a frame
        if (lst)
        begin
            track_hi = 8'd0;
            track_lo = 8'd255;
        end
        return r;
    endfunction

    // predict on input transfers, compare on output transfers
    always @(posedge clk)
    begin : result_check
        pixel_result_t want;
        pixel_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                scale_now = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.level = m_axis_tdata[PW-1:0];
                got.lo    = m_axis_tdata[2*PW-1:PW];
                got.hi    = m_axis_tdata[3*PW-1:2*PW];
                got.last  = m_axis_tlast;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing pending: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.level !== want.level)
                    begin
                        $error("pixel_out: expected %0d, got %0d", want.level, got.level);
                        mismatches++;
                    end
                    if (got.lo !== want.lo)
                    begin
                        $error("min_out: expected %0d, got %0d", want.lo, got.lo);
                        mismatches++;
                    end
                    if (got.hi !== want.hi)
                    begin
                        $error("max_out: expected %0d, got %0d", want.hi, got.hi);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_out: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_pixel(s_axis_tdata, s_axis_tlast);
                if (pin_fixed)
                    want.level = pin_level;
                pending_results.push_back(want);
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin : result_sink
        m_axis_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // offer one pixel and wait for its transfer
    task automatic send_pixel(input logic [PW-1:0] pix, input logic lst,
                              input logic fixed, input logic [PW-1:0] level);
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= lst;
        pin_fixed     <= fixed;
        pin_level     <= level;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
    endtask

    // stop offering and let every pending result come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_seen < pixels_sent)
            @(posedge clk);
        @(posedge clk);
    endtask

    // register write on the config channel
    task automatic write_scale(input logic [PW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        int            cur_scale;
        logic [PW-1:0] scale;
        logic [PW-1:0] pix;
        logic          lst;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        pin_fixed     <= 1'b0;
        pin_level     <= '0;
        scale_now     = 8'd255;
        track_lo      = 8'd255;
        track_hi      = 8'd0;
        pixels_sent   = 0;
        results_seen  = 0;
        mismatches    = 0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        hold_req      = 1'b0;
        cur_scale     = -1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (int k = 0; k < SCRIPT_ROWS; k++)
        begin
            if (int'(script[k].scale) != cur_scale)
            begin
                drain_results();
                write_scale(script[k].scale);
                cur_scale = int'(script[k].scale);
            end
            send_pixel(script[k].pix, script[k].last, script[k].fixed, script[k].level);
        end

        // random phases, each under its own scale
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: scale = 8'd255;
                1: scale = 8'd0;
                2: scale = 8'd1;
                3: scale = 8'd254;
                default: scale = 8'($urandom_range(2, 253));
            endcase
            drain_results();
            write_scale(scale);
            // no idling at the tail of the run, and none while the sink holds
            src_idle  = (ph < PHASES - 2) && (ph != 4);
            sink_idle = (ph < PHASES - 2);
            if (ph == 4)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                    pix = 8'($urandom_range(0, int'(scale)));
                else
                    pix = 8'($urandom_range(0, 255));
                lst = ($urandom_range(0, 11) == 0);
                send_pixel(pix, lst, 1'b0, 8'd0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** log_contrast_pixel_stream_unit: PASSED **");
        else
            $display("** log_contrast_pixel_stream_unit: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        #(2 * HALF_PERIOD * 400000);
        $display("** log_contrast_pixel_stream_unit: FAILED **");
        $finish;
    end

endmodule
